// ===== hw/rtl/mmt_pkg.sv =====
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared constants, codes and types of the matrix multiply engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mmt_pkg;

    // Geometry of the operand stores
    localparam int MAX_DIM    = 8;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = 2 * IDX_W;

    // Data widths
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int VALUE_W = 40;
    localparam int DIM_W   = 4;
    localparam int MODE_W  = 2;
    localparam int FUNC_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Transaction function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd2;

    // Operand modes; the unused code runs as plain A*B
    localparam logic [MODE_W-1:0] MODE_AB  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ATB = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPERAND_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESULT_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LENGTH = 2'd3;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [MODE_W-1:0] operand_mode;
        logic [DIM_W-1:0]  result_rows;
        logic [DIM_W-1:0]  result_cols;
        logic [DIM_W-1:0]  inner_length;
    } cfg_t;

    // Control tag that travels with each read pair down the datapath
    typedef struct packed {
        logic             valid;
        logic             first;     // first term of an element
        logic             last_term; // final term of an element
        logic             last_elem; // final element of the matrix
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } tag_t;

    // Highest counter value for a dimension register clamped to 1..MAX_DIM
    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] v);
        logic [IDX_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (v > DIM_W'(MAX_DIM))
            r = IDX_W'(MAX_DIM - 1);
        else
            r = IDX_W'(v - DIM_W'(1));
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mmt_ram.sv =====
// ----------------------------------------------------------------------------
// mmt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mmt_seq.sv =====
// ----------------------------------------------------------------------------
// mmt_seq
// Read sequencer: walks rows, columns and inner terms of the result and
// issues one read address pair per cycle with its control tag.
// ----------------------------------------------------------------------------
`default_nettype none

module mmt_seq
    import mmt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire cfg_t              cfg,
    output logic                   active,
    output logic      [ADDR_W-1:0] left_raddr,
    output logic      [ADDR_W-1:0] right_raddr,
    output tag_t                   tag
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] rows_last, cols_last, inner_last;
    logic             k_end, j_end, i_end;

    assign rows_last  = dim_last(cfg.result_rows);
    assign cols_last  = dim_last(cfg.result_cols);
    assign inner_last = dim_last(cfg.inner_length);

    assign k_end = (k_reg == inner_last);
    assign j_end = (j_reg == cols_last);
    assign i_end = (i_reg == rows_last);

    // Counter advance, innermost term first
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (!k_end)
                begin
                    k_next = k_reg + IDX_W'(1);
                end
                else
                begin
                    k_next = '0;
                    if (!j_end)
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_next = '0;
                        if (i_end)
                            state_next = ST_IDLE;
                        else
                            i_next = i_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
    end

    // Operand addresses per mode, address = {row, col}
    always_comb
    begin
        unique case (cfg.operand_mode)
            MODE_ATB:
            begin
                left_raddr  = {k_reg, i_reg};
                right_raddr = {k_reg, j_reg};
            end
            MODE_ABT:
            begin
                left_raddr  = {i_reg, k_reg};
                right_raddr = {j_reg, k_reg};
            end
            default:
            begin
                left_raddr  = {i_reg, k_reg};
                right_raddr = {k_reg, j_reg};
            end
        endcase
    end

    assign active = (state_reg == ST_RUN);

    // Tag for the read pair issued this cycle
    always_comb
    begin
        tag.valid     = active;
        tag.first     = (k_reg == '0);
        tag.last_term = k_end;
        tag.last_elem = i_end && j_end;
        tag.row       = i_reg;
        tag.col       = j_reg;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mmt_mac.sv =====
// ----------------------------------------------------------------------------
// mmt_mac
// Multiply-accumulate datapath: registered product, exact signed Q40.0 sum and
// the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmt_mac
    import mmt_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire tag_t                      tag_in,
    input  wire logic        [ELEM_W-1:0]  left_data,
    input  wire logic        [ELEM_W-1:0]  right_data,
    output logic                           pending,
    output logic                           out_valid,
    output logic             [IDX_W-1:0]   out_row,
    output logic             [IDX_W-1:0]   out_col,
    output logic signed      [VALUE_W-1:0] out_value,
    output logic                           last
);

    tag_t                      s1_reg, s2_reg;
    logic signed [ELEM_W-1:0]  a_op, b_op;
    logic signed [PROD_W-1:0]  prod_next, prod_reg;
    logic signed [VALUE_W-1:0] acc_reg, acc_base, acc_next;
    logic                      valid_reg;
    logic [IDX_W-1:0]          row_reg, col_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      last_reg;

    // Tag pipeline: s1 lines up with RAM data, s2 with the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
        end
        else
        begin
            s1_reg <= tag_in;
            s2_reg <= s1_reg;
        end
    end

    // Product stage
    assign a_op      = $signed(left_data);
    assign b_op      = $signed(right_data);
    assign prod_next = a_op * b_op;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Accumulate; first term restarts the sum
    assign acc_base = s2_reg.first ? '0 : acc_reg;
    assign acc_next = acc_base + VALUE_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (s2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= s2_reg.valid && s2_reg.last_term;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s2_reg.valid && s2_reg.last_term)
        begin
            row_reg   <= s2_reg.row;
            col_reg   <= s2_reg.col;
            value_reg <= acc_next;
            last_reg  <= s2_reg.last_elem;
        end
    end

    assign pending   = s1_reg.valid || s2_reg.valid;
    assign out_valid = valid_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign out_value = value_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/matrix_multiply_transpose_modes_top.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_transpose_modes_top
// 8x8 matrix multiply engine with A*B, transpose(A)*B and A*transpose(B).
//
//  Channel   Handshake            Payload
//  --------  -------------------  ------------------------------------------
//  command   start & !busy        func, row_index, col_index, element_value
//  result    out_valid (1 cycle)  out_row, out_col, out_value, last
//  config    cfg_we               cfg_index, cfg_data
//
// A load transaction writes one store entry. A start reads one operand
// pair per cycle from the two store RAMs and holds busy while reads issue
// and while the RAM read and product registers hold valid terms; the last
// result strobes in the same cycle that busy drops. One result leaves per
// product element. Reset clears control state and configuration, not the
// datapath registers or stores. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_transpose_modes_top
    import mmt_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic        [FUNC_W-1:0]  func,
    input  wire logic        [IDX_W-1:0]   row_index,
    input  wire logic        [IDX_W-1:0]   col_index,
    input  wire logic signed [ELEM_W-1:0]  element_value,
    input  wire logic                      cfg_we,
    input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    output logic             [IDX_W-1:0]   out_row,
    output logic             [IDX_W-1:0]   out_col,
    output logic signed      [VALUE_W-1:0] out_value,
    output logic                           last
);

    cfg_t              cfg_reg;
    logic              accept;
    logic              load_a, load_b, go;
    logic [ADDR_W-1:0] waddr;
    logic              active, pending;
    logic [ADDR_W-1:0] left_raddr, right_raddr;
    logic [ELEM_W-1:0] left_data, right_data;
    tag_t              issue_tag;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.operand_mode <= MODE_AB;
            cfg_reg.result_rows  <= DIM_W'(MAX_DIM);
            cfg_reg.result_cols  <= DIM_W'(MAX_DIM);
            cfg_reg.inner_length <= DIM_W'(MAX_DIM);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OPERAND_MODE: cfg_reg.operand_mode <= cfg_data[MODE_W-1:0];
                CFG_RESULT_ROWS:  cfg_reg.result_rows  <= cfg_data[DIM_W-1:0];
                CFG_RESULT_COLS:  cfg_reg.result_cols  <= cfg_data[DIM_W-1:0];
                CFG_INNER_LENGTH: cfg_reg.inner_length <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Command decode; func 3 is dropped
    assign accept = start && !busy;
    assign load_a = accept && (func == FUNC_LOAD_A);
    assign load_b = accept && (func == FUNC_LOAD_B);
    assign go     = accept && (func == FUNC_START);
    assign waddr  = {row_index, col_index};

    // Loads are only taken while idle, so store writes never meet reads
    assign busy = active || pending;

    mmt_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (STORE_DEPTH)
    ) u_left_store (
        .clk   (clk),
        .we    (load_a),
        .waddr (waddr),
        .wdata (element_value),
        .raddr (left_raddr),
        .rdata (left_data)
    );

    mmt_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (STORE_DEPTH)
    ) u_right_store (
        .clk   (clk),
        .we    (load_b),
        .waddr (waddr),
        .wdata (element_value),
        .raddr (right_raddr),
        .rdata (right_data)
    );

    mmt_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .cfg         (cfg_reg),
        .active      (active),
        .left_raddr  (left_raddr),
        .right_raddr (right_raddr),
        .tag         (issue_tag)
    );

    mmt_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag_in     (issue_tag),
        .left_data  (left_data),
        .right_data (right_data),
        .pending    (pending),
        .out_valid  (out_valid),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .last       (last)
    );

endmodule

`default_nettype wire

// ===== bench/tb_matrix_multiply_transpose_modes_top.sv =====
// ----------------------------------------------------------------------------
// tb_matrix_multiply_transpose_modes_top
// Self-checking bench for the 8x8 matrix multiply engine.
//
// Element loads and multiply starts go in through the command port, with
// random gaps between them. Every accepted transaction updates a predictor
// of both operand stores, each config write updates its configuration, and
// each start queues the full product matrix in row-major order. Every
// result strobe is checked against the oldest queued element. Stimulus opens
// with a directed pass over extreme values, all operand modes and clamped
// dimensions. It then runs random phases with fresh configurations, starting
// a multiply only once the operand region that its products read is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_matrix_multiply_transpose_modes_top;
    import mmt_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_LIST [4] = '{MODE_AB, MODE_ATB, MODE_ABT, MODE_SPARE};

    localparam int RANDOM_ITEMS  = 150;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    // One element of the product matrix as it leaves the engine
    typedef struct packed {
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } product_elem_t;

    // Predictor of the engine plus the queue of product elements in flight
    class matmul_scoreboard;
        logic signed [ELEM_W-1:0] left_elems  [STORE_DEPTH];
        logic signed [ELEM_W-1:0] right_elems [STORE_DEPTH];
        bit                       left_loaded  [STORE_DEPTH];
        bit                       right_loaded [STORE_DEPTH];
        cfg_t                     cfg;
        product_elem_t            expected_elems [$];
        int                       failures;

        function new();
            cfg.operand_mode = MODE_AB;
            cfg.result_rows  = DIM_W'(MAX_DIM);
            cfg.result_cols  = DIM_W'(MAX_DIM);
            cfg.inner_length = DIM_W'(MAX_DIM);
            failures = 0;
            foreach (left_loaded[n])
            begin
                left_loaded[n]  = 1'b0;
                right_loaded[n] = 1'b0;
            end
        endfunction

        // Dimension register as the engine uses it: 0 acts as 1, above 8 as 8
        function int span(logic [DIM_W-1:0] v);
            if (v == '0)
                return 1;
            if (v > DIM_W'(MAX_DIM))
                return MAX_DIM;
            return int'(v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OPERAND_MODE: cfg.operand_mode = data[MODE_W-1:0];
                CFG_RESULT_ROWS:  cfg.result_rows  = data;
                CFG_RESULT_COLS:  cfg.result_cols  = data;
                CFG_INNER_LENGTH: cfg.inner_length = data;
                default: ;
            endcase
        endfunction

        // Queue every element of C for the current mode and dimensions
        function void compute_product();
            int                       rows;
            int                       cols;
            int                       inner;
            longint                   acc;
            logic signed [ELEM_W-1:0] a;
            logic signed [ELEM_W-1:0] b;
            product_elem_t            e;
            rows  = span(cfg.result_rows);
            cols  = span(cfg.result_cols);
            inner = span(cfg.inner_length);
            for (int i = 0; i < rows; i++)
            begin
                for (int j = 0; j < cols; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < inner; k++)
                    begin
                        case (cfg.operand_mode)
                            MODE_ATB:
                            begin
                                a = left_elems[k * MAX_DIM + i];
                                b = right_elems[k * MAX_DIM + j];
                            end
                            MODE_ABT:
                            begin
                                a = left_elems[i * MAX_DIM + k];
                                b = right_elems[j * MAX_DIM + k];
                            end
                            default:
                            begin
                                a = left_elems[i * MAX_DIM + k];
                                b = right_elems[k * MAX_DIM + j];
                            end
                        endcase
                        acc += longint'(a) * longint'(b);
                    end
                    e.row   = IDX_W'(i);
                    e.col   = IDX_W'(j);
                    e.value = acc[VALUE_W-1:0];
                    e.last  = (i == rows - 1) && (j == cols - 1);
                    expected_elems.push_back(e);
                end
            end
        endfunction

        // Accepted command transaction
        function void note_command(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] r,
                                   logic [IDX_W-1:0] c, logic signed [ELEM_W-1:0] v);
            case (f)
                FUNC_LOAD_A:
                begin
                    left_elems[{r, c}]  = v;
                    left_loaded[{r, c}] = 1'b1;
                end
                FUNC_LOAD_B:
                begin
                    right_elems[{r, c}]  = v;
                    right_loaded[{r, c}] = 1'b1;
                end
                FUNC_START: compute_product();
                default: ;
            endcase
        endfunction

        // Result transaction against the oldest queued element
        function void check_result(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                   logic signed [VALUE_W-1:0] v, logic l);
            product_elem_t want;
            if (expected_elems.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result: row %0d col %0d value %0d last %0b",
                             r, c, v, l);
                return;
            end
            want = expected_elems.pop_front();
            if (r !== want.row || c !== want.col || v !== want.value || l !== want.last)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result mismatch: expected row %0d col %0d value %0d last %0b, got row %0d col %0d value %0d last %0b",
                             want.row, want.col, want.value, want.last, r, c, v, l);
            end
        endfunction
    endclass

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         start         = 1'b0;
    logic        [FUNC_W-1:0]     func          = FUNC_LOAD_A;
    logic        [IDX_W-1:0]      row_index     = '0;
    logic        [IDX_W-1:0]      col_index     = '0;
    logic signed [ELEM_W-1:0]     element_value = '0;
    logic                         cfg_we        = 1'b0;
    logic        [CFG_IDX_W-1:0]  cfg_index     = CFG_OPERAND_MODE;
    logic        [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                         busy;
    logic                         out_valid;
    logic        [IDX_W-1:0]      out_row;
    logic        [IDX_W-1:0]      out_col;
    logic signed [VALUE_W-1:0]    out_value;
    logic                         last;

    matmul_scoreboard sb;
    bit               in_burst = 1'b0;
    int               items_sent = 0;
    int               idle_cycles = 0;
    bit               need_left  [STORE_DEPTH];
    bit               need_right [STORE_DEPTH];

    matrix_multiply_transpose_modes_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_value     (out_value),
        .last          (last)
    );

    always #5 clk = ~clk;

    // Result checker; the strobe cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && out_valid)
            sb.check_result(out_row, out_col, out_value, last);
    end

    // Watchdog on cycles with no transaction on any port
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || out_valid || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function logic signed [ELEM_W-1:0] draw_value();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return '1;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // Mostly small sizes, with zero and oversize values that get clamped
    function logic [DIM_W-1:0] draw_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIM_W'($urandom_range(9, 15));
            2:       return DIM_W'(MAX_DIM);
            default: return DIM_W'($urandom_range(1, 4));
        endcase
    endfunction

    // Store entries that the next multiply will read
    function void build_needs();
        int rows;
        int cols;
        int inner;
        foreach (need_left[n])
        begin
            need_left[n]  = 1'b0;
            need_right[n] = 1'b0;
        end
        rows  = sb.span(sb.cfg.result_rows);
        cols  = sb.span(sb.cfg.result_cols);
        inner = sb.span(sb.cfg.inner_length);
        for (int i = 0; i < rows; i++)
            for (int j = 0; j < cols; j++)
                for (int k = 0; k < inner; k++)
                begin
                    case (sb.cfg.operand_mode)
                        MODE_ATB:
                        begin
                            need_left[k * MAX_DIM + i]  = 1'b1;
                            need_right[k * MAX_DIM + j] = 1'b1;
                        end
                        MODE_ABT:
                        begin
                            need_left[i * MAX_DIM + k]  = 1'b1;
                            need_right[j * MAX_DIM + k] = 1'b1;
                        end
                        default:
                        begin
                            need_left[i * MAX_DIM + k]  = 1'b1;
                            need_right[k * MAX_DIM + j] = 1'b1;
                        end
                    endcase
                end
    endfunction

    function bit operands_ready();
        build_needs();
        foreach (need_left[n])
            if ((need_left[n] && !sb.left_loaded[n]) || (need_right[n] && !sb.right_loaded[n]))
                return 1'b0;
        return 1'b1;
    endfunction

    // Sender gap before each transaction; none during a burst
    task automatic pace();
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One command transaction; start stays high if the next one follows at once
    task automatic issue(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                         logic signed [ELEM_W-1:0] v);
        pace();
        func          <= f;
        row_index     <= r;
        col_index     <= c;
        element_value <= v;
        start         <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(f, r, c, v);
        if (f != FUNC_UNUSED)
            items_sent++;
    endtask

    task automatic load(logic [FUNC_W-1:0] f, logic [ADDR_W-1:0] idx);
        issue(f, idx[ADDR_W-1:IDX_W], idx[IDX_W-1:0], draw_value());
    endtask

    // Load what the next multiply reads, refreshing some entries already held
    task automatic fill_operands();
        build_needs();
        for (int n = 0; n < STORE_DEPTH; n++)
        begin
            if (need_left[n] && (!sb.left_loaded[n] || $urandom_range(0, 2) == 0))
                load(FUNC_LOAD_A, ADDR_W'(n));
            if (need_right[n] && (!sb.right_loaded[n] || $urandom_range(0, 2) == 0))
                load(FUNC_LOAD_B, ADDR_W'(n));
        end
    endtask

    // Drain all queued elements, then allow the pipeline to empty
    task automatic settle();
        start <= 1'b0;
        while (sb.expected_elems.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // All four registers, back to back; mode write carries random upper bits
    task automatic write_config(logic [MODE_W-1:0] mode, logic [DIM_W-1:0] rows,
                                logic [DIM_W-1:0] cols, logic [DIM_W-1:0] inner);
        put_reg(CFG_OPERAND_MODE, {2'($urandom_range(0, 3)), mode});
        put_reg(CFG_RESULT_ROWS, rows);
        put_reg(CFG_RESULT_COLS, cols);
        put_reg(CFG_INNER_LENGTH, inner);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int choice;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme products on a 1x1 result
        write_config(MODE_AB, 4'd1, 4'd1, 4'd1);
        issue(FUNC_LOAD_A, 3'd0, 3'd0, 16'sh7FFF);
        issue(FUNC_LOAD_B, 3'd0, 3'd0, 16'sh8000);
        issue(FUNC_START, 3'd7, 3'd7, '1);
        issue(FUNC_LOAD_A, 3'd0, 3'd0, 16'sh8000);
        issue(FUNC_START, 3'd0, 3'd0, '0);
        // unused function code must leave the stores alone
        issue(FUNC_UNUSED, 3'd0, 3'd0, 16'sh1234);
        issue(FUNC_LOAD_A, 3'd7, 3'd7, 16'sh7FFF);
        issue(FUNC_LOAD_B, 3'd7, 3'd7, 16'sh8001);

        // Directed: every operand mode on a 2x2 problem
        for (int n = 0; n < 4; n++)
        begin
            issue(FUNC_LOAD_A, IDX_W'(n / 2), IDX_W'(n % 2), draw_value());
            issue(FUNC_LOAD_B, IDX_W'(n / 2), IDX_W'(n % 2), draw_value());
        end
        for (int m = 0; m < 4; m++)
        begin
            settle();
            write_config(MODE_LIST[m], 4'd2, 4'd2, 4'd2);
            issue(FUNC_START, 3'd0, 3'd0, '0);
        end

        // Directed: zero dimensions act as one
        settle();
        write_config(MODE_ABT, '0, '0, '0);
        issue(FUNC_START, 3'd5, 3'd2, 16'sh5555);

        // Random phases
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                settle();
                write_config(MODE_W'($urandom_range(0, 3)), draw_dim(), draw_dim(), draw_dim());
                in_burst = ($urandom_range(0, 2) == 0);
            end
            choice = $urandom_range(0, 9);
            if (choice == 0)
                load($urandom_range(0, 1) ? FUNC_LOAD_B : FUNC_LOAD_A,
                     ADDR_W'($urandom_range(0, STORE_DEPTH - 1)));
            else if (choice == 1)
                issue(FUNC_UNUSED, IDX_W'($urandom), IDX_W'($urandom), draw_value());
            else
            begin
                // bare start only when every read entry already holds data
                if (choice > 2 || !operands_ready())
                    fill_operands();
                issue(FUNC_START, IDX_W'($urandom), IDX_W'($urandom), draw_value());
            end
        end

        settle();
        if (sb.failures == 0 && sb.expected_elems.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
